### src/fixed_point_alu_top_defines.svh
// Assertion macros shared by the checker of the fixed-point ALU.
// Depends on nothing; the including file supplies the clock and reset names.
`ifndef FIXED_POINT_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_ALU_TOP_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define FPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define FPA_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

### src/fpa_pkg.sv
// Shared types, constants and the saturation function of the fixed-point ALU.
// Depends on nothing.
package fpa_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 8;
    localparam int NUM_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int DIV_STEPS     = NUM_BITS;
    localparam int PROD_BITS     = 2 * WORD_BITS;
    localparam int MAG_BITS      = PROD_BITS + 1 - FRACTION_BITS;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
        OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
        OP_MAX = 4'd12, OP_MIN = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
    } t_op;

    typedef struct packed {
        logic                 valid;
        t_op                  op;
        logic [WORD_BITS-1:0] res;
        logic                 cmp;
        logic                 dbz;
        logic                 neg;
        logic [WORD_BITS-1:0] den;
        logic [NUM_BITS-1:0]  num;
        logic [WORD_BITS-1:0] rem;
        logic [NUM_BITS-1:0]  quo;
        logic [PROD_BITS-1:0] prod;
    } t_stage;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 ovf;
    } t_sat;

    function automatic t_sat fpa_saturate(input logic [MAG_BITS-1:0] mag, input logic neg);
        t_sat r;
        logic [MAG_BITS-1:0] lim;
        lim = {{(MAG_BITS-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
        if (neg) begin
            r.ovf   = (mag > lim);
            r.value = r.ovf ? {1'b1, {(WORD_BITS-1){1'b0}}} : (~mag[WORD_BITS-1:0] + 1'b1);
        end else begin
            r.ovf   = (mag >= lim);
            r.value = r.ovf ? {1'b0, {(WORD_BITS-1){1'b1}}} : mag[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### src/fixed_point_alu_top.sv
// Top level of the Q24.8 fixed-point ALU: entry stage, divider chain, finish stage.
// Depends on fpa_pkg, fpa_div_stage and fpa_finish.
//
// Channel   Dir  Ports            Beat contents
// input     in   i_s_axis_*       tuser: operation; tdata: operand_a, operand_b
// result    out  o_m_axis_*       tdata: result_value, compare_true, divide_by_zero, overflow
//
// Every operation passes 42 register stages: one entry stage, 40 divider stages (one
// quotient bit each), and the finish stage. One beat per cycle unless output stalls.
// Reset is synchronous and clears only the valid bits of the stages.
// The whole pipeline holds while a result beat waits; nothing is lost or repeated.
module fixed_point_alu_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]  i_s_axis_tuser,   // [3:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [31:0] result_value, [32] compare_true,
                                          // [33] divide_by_zero, [34] overflow, rest zero
);

    localparam int W = fpa_pkg::WORD_BITS;

    logic                   w_en;
    logic signed [W-1:0]    w_a;
    logic signed [W-1:0]    w_b;
    logic [W-1:0]           w_ma;
    logic [W-1:0]           w_mb;
    fpa_pkg::t_op           w_op;
    fpa_pkg::t_stage        n_entry;
    fpa_pkg::t_stage        r_entry;
    fpa_pkg::t_stage        w_chain [0:fpa_pkg::DIV_STEPS];
    logic [W-1:0]           w_value;
    logic                   w_cmp;
    logic                   w_dbz;
    logic                   w_ovf;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_a  = i_s_axis_tdata[W-1:0];
    assign w_b  = i_s_axis_tdata[2*W-1:W];
    assign w_op = fpa_pkg::t_op'(i_s_axis_tuser);
    assign w_ma = w_a[W-1] ? (~w_a + 1'b1) : w_a;
    assign w_mb = w_b[W-1] ? (~w_b + 1'b1) : w_b;

    always_comb begin
        n_entry       = '0;
        n_entry.valid = i_s_axis_tvalid;
        n_entry.op    = w_op;
        n_entry.neg   = w_a[W-1] ^ w_b[W-1];
        n_entry.den   = w_mb;
        n_entry.num   = {w_ma, {fpa_pkg::FRACTION_BITS{1'b0}}};
        case (w_op)
            fpa_pkg::OP_ADD:      n_entry.res = w_a + w_b;
            fpa_pkg::OP_SUB:      n_entry.res = w_a - w_b;
            fpa_pkg::OP_DIV:      n_entry.dbz = (w_b == '0);
            fpa_pkg::OP_GT:       n_entry.cmp = (w_a > w_b);
            fpa_pkg::OP_LT:       n_entry.cmp = (w_a < w_b);
            fpa_pkg::OP_GE:       n_entry.cmp = (w_a >= w_b);
            fpa_pkg::OP_LE:       n_entry.cmp = (w_a <= w_b);
            fpa_pkg::OP_EQ:       n_entry.cmp = (w_a == w_b);
            fpa_pkg::OP_NE:       n_entry.cmp = (w_a != w_b);
            fpa_pkg::OP_INC:      n_entry.res = w_a + 1'b1;
            fpa_pkg::OP_DEC:      n_entry.res = w_a - 1'b1;
            fpa_pkg::OP_MAX:      n_entry.res = (w_a > w_b) ? w_a : w_b;
            fpa_pkg::OP_MIN:      n_entry.res = (w_a < w_b) ? w_a : w_b;
            fpa_pkg::OP_FROM_INT: n_entry.res = w_a << fpa_pkg::FRACTION_BITS;
            fpa_pkg::OP_TO_INT:   n_entry.res = w_a >>> fpa_pkg::FRACTION_BITS;
            default:              n_entry.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (w_en) begin
            r_entry.valid <= n_entry.valid;
        end
        if (w_en) begin
            r_entry.op   <= n_entry.op;
            r_entry.res  <= n_entry.res;
            r_entry.cmp  <= n_entry.cmp;
            r_entry.dbz  <= n_entry.dbz;
            r_entry.neg  <= n_entry.neg;
            r_entry.den  <= n_entry.den;
            r_entry.num  <= n_entry.num;
            r_entry.rem  <= n_entry.rem;
            r_entry.quo  <= n_entry.quo;
            r_entry.prod <= n_entry.prod;
        end
    end

    assign w_chain[0] = r_entry;

    for (genvar g = 0; g < fpa_pkg::DIV_STEPS; g++) begin : g_div
        fpa_div_stage #(
            .P_MUL (g == 0)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    fpa_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (w_chain[fpa_pkg::DIV_STEPS]),
        .o_valid (o_m_axis_tvalid),
        .o_value (w_value),
        .o_cmp   (w_cmp),
        .o_dbz   (w_dbz),
        .o_ovf   (w_ovf)
    );

    assign o_m_axis_tdata = {5'b0, w_ovf, w_dbz, w_cmp, w_value};

endmodule

### src/fpa_div_stage.sv
// One pipeline stage of the restoring divider: one quotient bit per stage.
// The first stage also forms the magnitude product. Depends on fpa_pkg.
module fpa_div_stage #(
    parameter bit P_MUL = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fpa_pkg::t_stage i_stage,
    output fpa_pkg::t_stage o_stage
);

    fpa_pkg::t_stage r_stage;
    fpa_pkg::t_stage n_stage;
    logic [fpa_pkg::WORD_BITS:0] w_r2;
    logic                        w_qbit;

    always_comb begin
        n_stage = i_stage;
        w_r2    = {i_stage.rem, i_stage.num[fpa_pkg::NUM_BITS-1]};
        w_qbit  = (w_r2 >= {1'b0, i_stage.den});
        n_stage.rem = w_qbit ? (w_r2[fpa_pkg::WORD_BITS-1:0] - i_stage.den)
                             : w_r2[fpa_pkg::WORD_BITS-1:0];
        n_stage.num = {i_stage.num[fpa_pkg::NUM_BITS-2:0], 1'b0};
        n_stage.quo = {i_stage.quo[fpa_pkg::NUM_BITS-2:0], w_qbit};
        if (P_MUL) begin
            n_stage.prod = i_stage.num[fpa_pkg::NUM_BITS-1:fpa_pkg::FRACTION_BITS]
                         * i_stage.den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.op   <= n_stage.op;
            r_stage.res  <= n_stage.res;
            r_stage.cmp  <= n_stage.cmp;
            r_stage.dbz  <= n_stage.dbz;
            r_stage.neg  <= n_stage.neg;
            r_stage.den  <= n_stage.den;
            r_stage.num  <= n_stage.num;
            r_stage.rem  <= n_stage.rem;
            r_stage.quo  <= n_stage.quo;
            r_stage.prod <= n_stage.prod;
        end
    end

    assign o_stage = r_stage;

endmodule

### src/fpa_finish.sv
// Final stage: rounds the quotient or product, saturates, and holds the result beat.
// Depends on fpa_pkg.
module fpa_finish (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  fpa_pkg::t_stage               i_stage,
    output logic                          o_valid,
    output logic [fpa_pkg::WORD_BITS-1:0] o_value,
    output logic                          o_cmp,
    output logic                          o_dbz,
    output logic                          o_ovf
);

    logic                          r_valid;
    logic [fpa_pkg::WORD_BITS-1:0] r_value;
    logic                          r_cmp;
    logic                          r_dbz;
    logic                          r_ovf;
    logic [fpa_pkg::WORD_BITS-1:0] n_value;
    logic                          n_ovf;
    logic                          w_up;
    logic [fpa_pkg::MAG_BITS-1:0]  w_qmag;
    logic [fpa_pkg::PROD_BITS:0]   w_pround;
    fpa_pkg::t_sat                 w_sat;

    always_comb begin
        w_up     = ({i_stage.rem, 1'b0} >= {1'b0, i_stage.den});
        w_qmag   = fpa_pkg::MAG_BITS'(i_stage.quo) + fpa_pkg::MAG_BITS'(w_up);
        w_pround = {1'b0, i_stage.prod}
                 + (fpa_pkg::PROD_BITS+1)'(1 << (fpa_pkg::FRACTION_BITS - 1));
        n_value  = i_stage.res;
        n_ovf    = 1'b0;
        w_sat    = '0;
        case (i_stage.op)
            fpa_pkg::OP_MUL: begin
                w_sat   = fpa_pkg::fpa_saturate(
                    w_pround[fpa_pkg::PROD_BITS:fpa_pkg::FRACTION_BITS], i_stage.neg);
                n_value = w_sat.value;
                n_ovf   = w_sat.ovf;
            end
            fpa_pkg::OP_DIV: begin
                if (!i_stage.dbz) begin
                    w_sat   = fpa_pkg::fpa_saturate(w_qmag, i_stage.neg);
                    n_value = w_sat.value;
                    n_ovf   = w_sat.ovf;
                end
            end
            default: begin
                n_value = i_stage.res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
        if (i_en) begin
            r_value <= n_value;
            r_cmp   <= i_stage.cmp;
            r_dbz   <= i_stage.dbz;
            r_ovf   <= n_ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_cmp   = r_cmp;
    assign o_dbz   = r_dbz;
    assign o_ovf   = r_ovf;

endmodule

### src/fpa_checker.sv
// Port-level checker of the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_top_defines.svh.
`include "fixed_point_alu_top_defines.svh"

module fpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    `FPA_ASSERT(a_hold_valid, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result beat dropped")
    `FPA_ASSERT(a_hold_data, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "stalled result changed")
    `FPA_ASSERT(a_ready_free, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled with empty output")
    `FPA_NEVER(a_dbz_clean, o_m_axis_tvalid && o_m_axis_tdata[33] && (o_m_axis_tdata[34] || o_m_axis_tdata[31:0] != 32'd0), "divide by zero with nonzero result")
    `FPA_NEVER(a_flags_excl, o_m_axis_tvalid && o_m_axis_tdata[32] && (o_m_axis_tdata[33] || o_m_axis_tdata[34]), "compare with arithmetic flag")

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
